### rtl/sbrr_pkg.sv
// Shared types, command codes and sizes for the slot buffer with round-robin pick.
package sbrr_pkg;

    localparam int SLOTS_DEF = 8;

    localparam int CMD_W  = 2;
    localparam int WAIT_W = 32;
    localparam int SRC_W  = 8;
    localparam int REQ_W  = 24;
    localparam int SLOT_W = 3;
    localparam int PAY_W  = WAIT_W + SRC_W + REQ_W;

    localparam logic [CMD_W-1:0] CMD_ADD    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_TAKE   = 2'd2;
    localparam logic [CMD_W-1:0] CMD_STATUS = 2'd3;

    typedef logic [PAY_W-1:0] t_payload;

    // Result of one pass of the priority finder.
    typedef struct packed {
        logic       hit;
        logic [5:0] idx;
    } t_pick;

endpackage

### rtl/sbrr_pick.sv
// Priority finder: returns the lowest set position of a slot vector.
module sbrr_pick #(
    parameter int SLOTS = sbrr_pkg::SLOTS_DEF
) (
    input  logic [SLOTS-1:0] i_vec,
    output sbrr_pkg::t_pick  o_pick
);

    always_comb begin
        o_pick = '0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (i_vec[i]) begin
                o_pick.hit = 1'b1;
                o_pick.idx = 6'(i);
            end
        end
    end

endmodule

### rtl/slot_buffer_round_robin.sv
// Top level of the slot buffer: sequencer, occupancy flags, payload memory, cursor.
//
//  channel   handshake              payload
//  --------  ---------------------  ---------------------------------------------------
//  command   start / busy           i_command, i_wait_time, i_source_id, i_request_number
//  result    o_valid (1 cycle)      o_found, o_slot, o_out_*, o_has_free, o_is_empty
//
// The result strobe of a word follows a search step and a read step; a round-robin take
// that wraps past the end repeats the search step: the single priority finder is used once
// per pass, and a take that sees nothing at or above the cursor makes a second, unmasked
// pass. The payload memory read is registered in the search step; the next word is
// accepted at the earliest on the edge that takes the result.
// Reset clears occupancy, the cursor and the sequencer; payload memory is not cleared.
// busy stays high from acceptance until the result is strobed; results cannot be stalled.
module slot_buffer_round_robin #(
    parameter int SLOTS = sbrr_pkg::SLOTS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [sbrr_pkg::CMD_W-1:0]    i_command,
    input  logic [sbrr_pkg::WAIT_W-1:0]   i_wait_time,
    input  logic [sbrr_pkg::SRC_W-1:0]    i_source_id,
    input  logic [sbrr_pkg::REQ_W-1:0]    i_request_number,
    output logic                          o_valid,
    output logic                          o_found,
    output logic [sbrr_pkg::SLOT_W-1:0]   o_slot,
    output logic [sbrr_pkg::WAIT_W-1:0]   o_out_wait_time,
    output logic [sbrr_pkg::SRC_W-1:0]    o_out_source_id,
    output logic [sbrr_pkg::REQ_W-1:0]    o_out_request_number,
    output logic                          o_has_free,
    output logic                          o_is_empty
);

    localparam int IdxW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SRCH = 2'd1;
    localparam logic [1:0] ST_READ = 2'd2;

    logic [1:0]                    r_state, n_state;
    logic                          r_pass, n_pass;
    logic [sbrr_pkg::CMD_W-1:0]    r_cmd;
    sbrr_pkg::t_payload            r_wdata;
    logic [SLOTS-1:0]              r_occ, n_occ;
    logic [IdxW-1:0]               r_cursor, n_cursor;
    logic                          r_found, n_found;
    logic [IdxW-1:0]               r_idx, n_idx;
    sbrr_pkg::t_payload            r_rdata;
    sbrr_pkg::t_payload            mem [SLOTS];

    logic [SLOTS-1:0]              ge_mask;
    logic [SLOTS-1:0]              pick_vec;
    sbrr_pkg::t_pick               pick;
    logic [IdxW-1:0]               pick_idx;
    logic                          mem_we;
    logic                          accept;

    assign busy     = (r_state != ST_IDLE);
    assign accept   = start && !busy;
    assign pick_idx = pick.idx[IdxW-1:0];

    // Slots at or above the cursor, for the first pass of a take.
    always_comb begin
        for (int i = 0; i < SLOTS; i++) begin
            ge_mask[i] = (IdxW'(i) >= r_cursor);
        end
    end

    always_comb begin
        if (r_cmd == sbrr_pkg::CMD_ADD) begin
            pick_vec = ~r_occ;
        end else if (r_cmd == sbrr_pkg::CMD_TAKE && !r_pass) begin
            pick_vec = r_occ & ge_mask;
        end else begin
            pick_vec = r_occ;
        end
    end

    sbrr_pick #(
        .SLOTS (SLOTS)
    ) u_pick (
        .i_vec  (pick_vec),
        .o_pick (pick)
    );

    always_comb begin
        n_state  = r_state;
        n_pass   = r_pass;
        n_occ    = r_occ;
        n_cursor = r_cursor;
        n_found  = r_found;
        n_idx    = r_idx;
        mem_we   = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_state = ST_SRCH;
                    n_pass  = 1'b0;
                    n_found = 1'b0;
                    n_idx   = '0;
                end
            end
            ST_SRCH: begin
                n_state = ST_READ;
                case (r_cmd)
                    sbrr_pkg::CMD_ADD: begin
                        if (pick.hit) begin
                            n_found         = 1'b1;
                            n_idx           = pick_idx;
                            n_occ[pick_idx] = 1'b1;
                            mem_we          = 1'b1;
                        end
                    end
                    sbrr_pkg::CMD_REMOVE: begin
                        if (pick.hit) begin
                            n_found         = 1'b1;
                            n_idx           = pick_idx;
                            n_occ[pick_idx] = 1'b0;
                        end
                    end
                    sbrr_pkg::CMD_TAKE: begin
                        if (pick.hit) begin
                            n_found         = 1'b1;
                            n_idx           = pick_idx;
                            n_occ[pick_idx] = 1'b0;
                            n_cursor        = (pick_idx == IdxW'(SLOTS - 1)) ?
                                              '0 : pick_idx + 1'b1;
                        end else if (!r_pass) begin
                            // Nothing at or above the cursor: wrap and search from zero.
                            n_pass  = 1'b1;
                            n_state = ST_SRCH;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            ST_READ: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_pass   <= 1'b0;
            r_occ    <= '0;
            r_cursor <= '0;
            r_found  <= 1'b0;
            r_idx    <= '0;
            o_valid  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_pass   <= n_pass;
            r_occ    <= n_occ;
            r_cursor <= n_cursor;
            r_found  <= n_found;
            r_idx    <= n_idx;
            o_valid  <= (r_state == ST_READ);
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd   <= i_command;
            r_wdata <= {i_wait_time, i_source_id, i_request_number};
        end
    end

    // Payload memory: one write port, one registered read port, both at the picked slot.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[pick_idx] <= r_wdata;
        end
        r_rdata <= mem[pick_idx];
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_READ) begin
            o_found    <= r_found;
            o_slot     <= sbrr_pkg::SLOT_W'(r_idx);
            o_has_free <= ~&r_occ;
            o_is_empty <= ~|r_occ;
            if (r_found && r_cmd != sbrr_pkg::CMD_ADD) begin
                {o_out_wait_time, o_out_source_id, o_out_request_number} <= r_rdata;
            end else begin
                {o_out_wait_time, o_out_source_id, o_out_request_number} <= '0;
            end
        end
    end

    a_empty_has_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_is_empty |-> o_has_free)
        else $error("empty buffer reported without a free slot");

    a_miss_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_found |-> o_slot == '0 && o_out_wait_time == '0
                                && o_out_request_number == '0)
        else $error("result fields not zero on a miss");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("sequencer did not start on an accepted word");

    a_strobe_after_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy && $past(r_state) == ST_READ)
        else $error("result strobe outside the read step");

endmodule
